// ===== src/stack_with_bottom_removal_assert.svh =====
// assertion macros used by the checker
`ifndef STACK_WITH_BOTTOM_REMOVAL_ASSERT_SVH
`define STACK_WITH_BOTTOM_REMOVAL_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SWBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled while reset is low
`define SWBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== src/swbr_pkg.sv =====
package swbr_pkg;

    // default geometry
    localparam int DEPTH_DEFAULT      = 64;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // fixed field widths
    localparam int FUNC_WIDTH   = 2;
    localparam int INDEX_WIDTH  = 6;
    localparam int STATUS_WIDTH = 2;

    // operation codes
    typedef enum logic [FUNC_WIDTH-1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_REMOVE = 2'd3
    } t_func;

    // result status codes
    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_RANGE = 2'd3
    } t_status;

    // control states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

endpackage

// ===== src/swbr_ram.sv =====
module swbr_ram #(
    parameter int WIDTH = swbr_pkg::DATA_WIDTH_DEFAULT,
    parameter int DEPTH = swbr_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/stack_with_bottom_removal.sv =====
// bounded stack with bottom (oldest) removal, elements held in a single ring-buffer ram
// result strobe o_valid is registered from the execute state entered on accept
// a new item is taken only while not busy (accept cycle issues the ram read,
//   execute cycle uses the read data and writes back a pushed element)
// reset: synchronous active-low, empties the stack; ram contents are left as is
// results cannot be stalled: each is shown for exactly one cycle
module stack_with_bottom_removal #(
    parameter int DEPTH      = swbr_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = swbr_pkg::DATA_WIDTH_DEFAULT,
    localparam int AW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [swbr_pkg::FUNC_WIDTH-1:0]    i_func,
    input  logic [DATA_WIDTH-1:0]              i_push_value,
    input  logic [swbr_pkg::INDEX_WIDTH-1:0]   i_index,
    output logic                               o_valid,
    output logic [DATA_WIDTH-1:0]              o_read_value,
    output logic [swbr_pkg::STATUS_WIDTH-1:0]  o_status,
    output logic [CW-1:0]                      o_count,
    output logic                               o_is_empty,
    output logic [DATA_WIDTH-1:0]              o_top_value
);

    localparam int IDXW = swbr_pkg::INDEX_WIDTH;
    localparam int XW   = ((AW > IDXW) ? AW : IDXW) + 1;
    localparam int CMPW = (CW > IDXW) ? CW : IDXW;

    swbr_pkg::t_state  r_state, n_state;
    logic [AW-1:0]     r_top, n_top;
    logic [CW-1:0]     r_count, n_count;
    logic [DATA_WIDTH-1:0] r_top_val, n_top_val;

    // item captured at accept
    swbr_pkg::t_func   r_func;
    logic [DATA_WIDTH-1:0] r_push_value;
    logic [IDXW-1:0]   r_index;

    // result registers
    logic              r_valid;
    logic [DATA_WIDTH-1:0] r_read_value, n_read_value;
    swbr_pkg::t_status r_status, n_status;
    logic [CW-1:0]     r_count_out;
    logic              r_is_empty;
    logic [DATA_WIDTH-1:0] r_top_out, n_top_out;

    logic              accept;
    logic              exec;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [XW-1:0]     rd_off;
    logic [XW-1:0]     rd_diff;
    logic [AW-1:0]     top_inc;
    logic [AW-1:0]     top_dec;
    logic              st_empty;
    logic              st_full;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swbr_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = swbr_pkg::ST_EXEC;
                end
            end
            swbr_pkg::ST_EXEC: begin
                n_state = swbr_pkg::ST_IDLE;
            end
            default: begin
                n_state = swbr_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        busy = 1'b0;
        exec = 1'b0;
        unique case (r_state)
            swbr_pkg::ST_IDLE: begin
                busy = 1'b0;
                exec = 1'b0;
            end
            swbr_pkg::ST_EXEC: begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default: begin
                busy = 1'b0;
                exec = 1'b0;
            end
        endcase
    end

    assign accept = start && !busy;

    // read address: slot that lies rd_off below the top, wrapping
    always_comb begin
        case (swbr_pkg::t_func'(i_func))
            swbr_pkg::FUNC_POP:    rd_off = XW'(1);
            swbr_pkg::FUNC_READ:   rd_off = XW'(i_index);
            swbr_pkg::FUNC_REMOVE: rd_off = XW'(r_count) - XW'(1);
            default:               rd_off = '0;
        endcase
        rd_diff = XW'(r_top) - rd_off;
        if (rd_diff[XW-1]) begin
            rd_diff = rd_diff + XW'(DEPTH);
        end
        ram_raddr = rd_diff[AW-1:0];
    end

    // ring neighbors of the top slot
    assign top_inc  = (r_top == AW'(DEPTH - 1)) ? '0 : r_top + AW'(1);
    assign top_dec  = (r_top == '0) ? AW'(DEPTH - 1) : r_top - AW'(1);
    assign st_empty = (r_count == '0);
    assign st_full  = (r_count == CW'(DEPTH));

    // execute: apply the operation and form the result
    always_comb begin
        n_top        = r_top;
        n_count      = r_count;
        n_top_val    = r_top_val;
        n_read_value = '0;
        n_status     = swbr_pkg::STATUS_OK;
        ram_we       = 1'b0;
        ram_waddr    = top_inc;
        case (r_func)
            swbr_pkg::FUNC_PUSH: begin
                if (st_full) begin
                    n_status = swbr_pkg::STATUS_FULL;
                end else begin
                    n_top     = st_empty ? '0 : top_inc;
                    ram_we    = exec;
                    ram_waddr = n_top;
                    n_count   = r_count + CW'(1);
                    n_top_val = r_push_value;
                end
            end
            swbr_pkg::FUNC_POP: begin
                if (st_empty) begin
                    n_status = swbr_pkg::STATUS_EMPTY;
                end else begin
                    n_read_value = r_top_val;
                    n_top        = top_dec;
                    n_count      = r_count - CW'(1);
                    n_top_val    = ram_rdata;
                end
            end
            swbr_pkg::FUNC_READ: begin
                if (st_empty) begin
                    n_status = swbr_pkg::STATUS_EMPTY;
                end else if (CMPW'(r_index) >= CMPW'(r_count)) begin
                    n_status = swbr_pkg::STATUS_RANGE;
                end else begin
                    n_read_value = ram_rdata;
                end
            end
            default: begin
                if (st_empty) begin
                    n_status = swbr_pkg::STATUS_EMPTY;
                end else begin
                    n_read_value = ram_rdata;
                    n_count      = r_count - CW'(1);
                end
            end
        endcase
        n_top_out = (n_count == '0) ? '0 : n_top_val;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swbr_pkg::ST_IDLE;
            r_top   <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= exec;
            if (exec) begin
                r_top   <= n_top;
                r_count <= n_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func       <= swbr_pkg::t_func'(i_func);
            r_push_value <= i_push_value;
            r_index      <= i_index;
        end
        if (exec) begin
            r_top_val    <= n_top_val;
            r_read_value <= n_read_value;
            r_status     <= n_status;
            r_count_out  <= n_count;
            r_is_empty   <= (n_count == '0);
            r_top_out    <= n_top_out;
        end
    end

    // element storage
    swbr_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_push_value),
        .i_re    (accept),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_valid      = r_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count      = r_count_out;
    assign o_is_empty   = r_is_empty;
    assign o_top_value  = r_top_out;

endmodule

// ===== src/swbr_checker.sv =====
`include "stack_with_bottom_removal_assert.svh"

module swbr_checker #(
    parameter int DEPTH      = swbr_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = swbr_pkg::DATA_WIDTH_DEFAULT,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_valid,
    input logic [DATA_WIDTH-1:0]              o_read_value,
    input logic [swbr_pkg::STATUS_WIDTH-1:0]  o_status,
    input logic [CW-1:0]                      o_count,
    input logic                               o_is_empty,
    input logic [DATA_WIDTH-1:0]              o_top_value
);

    // empty flag agrees with the count
    `SWBR_ASSERT_NOW(a_empty_flag, i_clk, i_rst_n, o_valid, o_is_empty == (o_count == '0))

    // an empty stack reports a zero top; every count stays within the depth
    `SWBR_ASSERT_NOW(a_empty_top, i_clk, i_rst_n, o_valid && o_is_empty, o_top_value == '0)
    `SWBR_ASSERT_NOW(a_count_range, i_clk, i_rst_n, o_valid, o_count <= CW'(DEPTH))

    // failed operation reads zero
    `SWBR_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_valid && (o_status != swbr_pkg::STATUS_OK), o_read_value == '0)

    // an accepted item keeps the block busy, then yields its result
    `SWBR_ASSERT_NEXT(a_accept_result, i_clk, i_rst_n, start && !busy, busy ##1 o_valid)

endmodule

bind stack_with_bottom_removal swbr_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_swbr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_read_value (o_read_value),
    .o_status     (o_status),
    .o_count      (o_count),
    .o_is_empty   (o_is_empty),
    .o_top_value  (o_top_value)
);
